FILE: rtl/gctp_pkg.sv
// gctp_pkg: shared widths, codes, types and arithmetic helpers of the gc trigger policy.
// Depends on nothing; imported by gc_trigger_policy.
package gctp_pkg;

  // field widths
  localparam int BYTE_W  = 40;
  localparam int TIME_W  = 32;
  localparam int DUR_W   = 32;
  localparam int CNT_W   = 32;
  localparam int GAIN_W  = 12;
  localparam int SMOOTH_W = 9;
  localparam int FRAG_W  = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // reset values of the configuration registers
  localparam logic [BYTE_W-1:0]   NURSERY_LIMIT_RST = BYTE_W'(262144);
  localparam logic [BYTE_W-1:0]   MAJOR_FLOOR_RST   = BYTE_W'(4194304);
  localparam logic [GAIN_W-1:0]   GROWTH_GAIN_RST   = GAIN_W'(435);
  localparam logic [TIME_W-1:0]   TIME_LIMIT_RST    = TIME_W'(30000);
  localparam logic [SMOOTH_W-1:0] SMOOTH_GAIN_RST   = SMOOTH_W'(179);

  // smoothing weight of one, and the fragmentation level that asks for compaction
  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE   = SMOOTH_W'(256);
  localparam logic [FRAG_W-1:0]   FRAG_COMPACT = FRAG_W'(77);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NURSERY_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_FLOOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_GAIN   = 3'd4;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_CHECK    = 3'd1,
    ACT_SELECT   = 3'd2,
    ACT_ALLOC    = 3'd3,
    ACT_COMPLETE = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    TRG_NONE      = 3'd0,
    TRG_BUDGET    = 3'd1,
    TRG_TIME      = 3'd2,
    TRG_IDLE      = 3'd3,
    TRG_PRESSURE  = 3'd4,
    TRG_PROACTIVE = 3'd5,
    TRG_EXPLICIT  = 3'd6
  } trig_t;

  typedef enum logic [1:0] {
    KIND_MINOR   = 2'd0,
    KIND_MAJOR   = 2'd1,
    KIND_FULL    = 2'd2,
    KIND_COMPACT = 2'd3
  } kind_t;

  // state snapshot carried down the result pipeline
  typedef struct packed {
    trig_t              trig;
    kind_t              kind;
    logic [BYTE_W-1:0]  alloc;
    logic [BYTE_W-1:0]  live_est;
    logic [BYTE_W-1:0]  last_live;
    logic [DUR_W-1:0]   dur_est;
    logic [CNT_W-1:0]   count;
  } snap_t;

  // floor(v * g / 256), saturated to the byte width
  function automatic logic [BYTE_W-1:0] scale_q8(input logic [BYTE_W-1:0] v,
                                                 input logic [GAIN_W-1:0] g);
    logic [BYTE_W+GAIN_W-1:0] p;
    p = (BYTE_W+GAIN_W)'(v) * (BYTE_W+GAIN_W)'(g);
    if (|p[BYTE_W+GAIN_W-1:BYTE_W+8]) begin
      return '1;
    end
    return p[BYTE_W+7:8];
  endfunction

  // collection kind for a trigger
  function automatic kind_t kind_for(input trig_t trig, input logic [BYTE_W-1:0] heap,
                                     input logic [BYTE_W-1:0] floor_bytes,
                                     input logic [FRAG_W-1:0] frag);
    kind_t k;
    case (trig)
      TRG_BUDGET: begin
        if (heap < floor_bytes) k = KIND_MINOR;
        else if (frag >= FRAG_COMPACT) k = KIND_COMPACT;
        else k = KIND_MAJOR;
      end
      TRG_TIME, TRG_PROACTIVE: k = KIND_MAJOR;
      TRG_PRESSURE, TRG_EXPLICIT: k = KIND_FULL;
      default: k = KIND_MINOR;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/gc_trigger_policy.sv
// gc_trigger_policy: event-driven garbage-collection scheduler, top level.
// Depends on gctp_pkg for widths, codes, the snapshot type, the q8 scaling and the kind helper.
//
// One request (tick, check, select, allocation or completion) is taken per clock while
// in_ready is high, and every request returns exactly one result, in order. Each request
// passes an input register, then the state update with trigger and kind, then the
// growth scaling of the live estimate, then the threshold subtraction into the output
// register. Each stage holds its item only while the one after it is full, so the input
// side keeps taking requests while a result waits, until all four stage registers hold
// a request; then in_ready drops.
// The sustained figure of one request per cycle, while results are taken, rests on the
// combinational state update after the input register (smoothing and threshold products).
// Configuration writes are always taken and must only be issued while no request
// is in flight.
module gc_trigger_policy (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gctp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gctp_pkg::CFG_DATA_W-1:0]    cfg_data,
  // requests
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_action,
  input  logic [gctp_pkg::BYTE_W-1:0]        in_heap_bytes,
  input  logic [gctp_pkg::BYTE_W-1:0]        in_nursery_used,
  input  logic [gctp_pkg::BYTE_W-1:0]        in_live_bytes,
  input  logic [gctp_pkg::FRAG_W-1:0]        in_fragmentation,
  input  logic [2:0]                         in_trigger_in,
  input  logic [gctp_pkg::BYTE_W-1:0]        in_alloc_bytes,
  input  logic [gctp_pkg::DUR_W-1:0]         in_duration,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_trigger,
  output logic [1:0]                         out_kind,
  output logic [gctp_pkg::BYTE_W-1:0]        out_bytes_until_gc,
  output logic [gctp_pkg::BYTE_W-1:0]        out_predicted_live,
  output logic [gctp_pkg::BYTE_W-1:0]        out_last_live,
  output logic [gctp_pkg::DUR_W-1:0]         out_mean_duration,
  output logic [gctp_pkg::CNT_W-1:0]         out_collections
);
  import gctp_pkg::*;

  // configuration registers
  logic [BYTE_W-1:0]   nursery_limit_r;
  logic [BYTE_W-1:0]   major_floor_r;
  logic [GAIN_W-1:0]   growth_gain_r;
  logic [TIME_W-1:0]   time_limit_r;
  logic [SMOOTH_W-1:0] smooth_gain_r;

  // scheduler state
  logic [TIME_W-1:0] elapsed_r,   elapsed_nxt;
  logic [BYTE_W-1:0] last_live_r, last_live_nxt;
  logic [BYTE_W-1:0] alloc_r,     alloc_nxt;
  logic [BYTE_W-1:0] live_est_r,  live_est_nxt;
  logic [DUR_W-1:0]  dur_est_r,   dur_est_nxt;
  logic [CNT_W-1:0]  count_r,     count_nxt;

  // input stage
  logic              a_vld_r;
  logic [2:0]        a_action_r;
  logic [BYTE_W-1:0] a_heap_r;
  logic [BYTE_W-1:0] a_nursery_r;
  logic [BYTE_W-1:0] a_live_r;
  logic [FRAG_W-1:0] a_frag_r;
  logic [2:0]        a_tin_r;
  logic [BYTE_W-1:0] a_alloc_r;
  logic [DUR_W-1:0]  a_dur_r;

  // result pipeline
  logic              b_vld_r, c_vld_r, out_vld_r;
  snap_t             b_snap_r, c_snap_r, out_snap_r, b_snap_nxt;
  logic [BYTE_W-1:0] c_scaled_r;
  logic [BYTE_W-1:0] out_bytes_r, out_bytes_nxt;

  // stage handshakes
  logic o_rdy, c_rdy, b_rdy, a_rdy, a_go;

  assign o_rdy    = !out_vld_r || out_ready;
  assign c_rdy    = !c_vld_r || o_rdy;
  assign b_rdy    = !b_vld_r || c_rdy;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign a_go     = a_vld_r && b_rdy;
  assign in_ready = a_rdy;
  assign cfg_ready = 1'b1;

  // smoothing weights, new sample weight capped at one
  logic [SMOOTH_W-1:0]   g_new, g_old;
  logic [BYTE_W+8:0]     live_sum;
  logic [DUR_W+8:0]      dur_sum;
  logic [BYTE_W-1:0]     check_thr;
  trig_t                 trig;
  kind_t                 kind;

  always_comb begin
    g_new = (smooth_gain_r > SMOOTH_ONE) ? SMOOTH_ONE : smooth_gain_r;
    g_old = SMOOTH_ONE - g_new;
    live_sum = (BYTE_W+9)'(a_live_r) * (BYTE_W+9)'(g_new)
             + (BYTE_W+9)'(live_est_r) * (BYTE_W+9)'(g_old);
    dur_sum  = (DUR_W+9)'(a_dur_r) * (DUR_W+9)'(g_new)
             + (DUR_W+9)'(dur_est_r) * (DUR_W+9)'(g_old);
  end

  // major threshold of the last live size, for the check
  always_comb begin
    check_thr = scale_q8(last_live_r, growth_gain_r);
    if (check_thr < major_floor_r) begin
      check_thr = major_floor_r;
    end
  end

  // request decode: state update, trigger and kind
  always_comb begin
    elapsed_nxt   = elapsed_r;
    last_live_nxt = last_live_r;
    alloc_nxt     = alloc_r;
    live_est_nxt  = live_est_r;
    dur_est_nxt   = dur_est_r;
    count_nxt     = count_r;
    trig          = TRG_NONE;
    kind          = KIND_MINOR;
    unique case (action_t'(a_action_r))
      ACT_TICK: begin
        if (elapsed_r != '1) elapsed_nxt = elapsed_r + TIME_W'(1);
      end
      ACT_CHECK: begin
        if (a_nursery_r >= nursery_limit_r) trig = TRG_BUDGET;
        else if (a_heap_r >= check_thr) trig = TRG_BUDGET;
        else if (elapsed_r >= time_limit_r) trig = TRG_TIME;
        kind = kind_for(trig, a_heap_r, major_floor_r, a_frag_r);
      end
      ACT_SELECT: begin
        trig = (a_tin_r > 3'(TRG_EXPLICIT)) ? TRG_NONE : trig_t'(a_tin_r);
        kind = kind_for(trig, a_heap_r, major_floor_r, a_frag_r);
      end
      ACT_ALLOC: begin
        if (('1 - alloc_r) < a_alloc_r) alloc_nxt = '1;
        else alloc_nxt = alloc_r + a_alloc_r;
      end
      ACT_COMPLETE: begin
        elapsed_nxt   = '0;
        alloc_nxt     = '0;
        if (count_r != '1) count_nxt = count_r + CNT_W'(1);
        live_est_nxt  = (live_est_r == '0) ? a_live_r : live_sum[BYTE_W+7:8];
        dur_est_nxt   = (dur_est_r == '0) ? a_dur_r : dur_sum[DUR_W+7:8];
        last_live_nxt = a_live_r;
      end
      default: begin
      end
    endcase
    b_snap_nxt = '{trig: trig, kind: kind, alloc: alloc_nxt, live_est: live_est_nxt,
                   last_live: last_live_nxt, dur_est: dur_est_nxt, count: count_nxt};
  end

  // remaining budget against the scaled live estimate
  logic [BYTE_W-1:0] est_thr;

  always_comb begin
    est_thr = (c_scaled_r > major_floor_r) ? c_scaled_r : major_floor_r;
    out_bytes_nxt = (est_thr > c_snap_r.alloc) ? est_thr - c_snap_r.alloc : '0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nursery_limit_r <= NURSERY_LIMIT_RST;
      major_floor_r   <= MAJOR_FLOOR_RST;
      growth_gain_r   <= GROWTH_GAIN_RST;
      time_limit_r    <= TIME_LIMIT_RST;
      smooth_gain_r   <= SMOOTH_GAIN_RST;
      elapsed_r       <= '0;
      last_live_r     <= '0;
      alloc_r         <= '0;
      live_est_r      <= '0;
      dur_est_r       <= '0;
      count_r         <= '0;
      a_vld_r         <= 1'b0;
      b_vld_r         <= 1'b0;
      c_vld_r         <= 1'b0;
      out_vld_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_NURSERY_LIMIT: nursery_limit_r <= cfg_data[BYTE_W-1:0];
          CFG_MAJOR_FLOOR:   major_floor_r   <= cfg_data[BYTE_W-1:0];
          CFG_GROWTH_GAIN:   growth_gain_r   <= cfg_data[GAIN_W-1:0];
          CFG_TIME_LIMIT:    time_limit_r    <= cfg_data[TIME_W-1:0];
          CFG_SMOOTH_GAIN:   smooth_gain_r   <= cfg_data[SMOOTH_W-1:0];
          default: begin
          end
        endcase
      end
      if (a_go) begin
        elapsed_r   <= elapsed_nxt;
        last_live_r <= last_live_nxt;
        alloc_r     <= alloc_nxt;
        live_est_r  <= live_est_nxt;
        dur_est_r   <= dur_est_nxt;
        count_r     <= count_nxt;
      end
      if (a_rdy) a_vld_r <= in_valid;
      if (b_rdy) b_vld_r <= a_vld_r;
      if (c_rdy) c_vld_r <= b_vld_r;
      if (o_rdy) out_vld_r <= c_vld_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_action_r  <= in_action;
      a_heap_r    <= in_heap_bytes;
      a_nursery_r <= in_nursery_used;
      a_live_r    <= in_live_bytes;
      a_frag_r    <= in_fragmentation;
      a_tin_r     <= in_trigger_in;
      a_alloc_r   <= in_alloc_bytes;
      a_dur_r     <= in_duration;
    end
    if (a_go) begin
      b_snap_r <= b_snap_nxt;
    end
    if (b_vld_r && c_rdy) begin
      c_snap_r   <= b_snap_r;
      c_scaled_r <= scale_q8(b_snap_r.live_est, growth_gain_r);
    end
    if (c_vld_r && o_rdy) begin
      out_snap_r  <= c_snap_r;
      out_bytes_r <= out_bytes_nxt;
    end
  end

  // result ports
  assign out_valid          = out_vld_r;
  assign out_trigger        = out_snap_r.trig;
  assign out_kind           = out_snap_r.kind;
  assign out_bytes_until_gc = out_bytes_r;
  assign out_predicted_live = out_snap_r.live_est;
  assign out_last_live      = out_snap_r.last_live;
  assign out_mean_duration  = out_snap_r.dur_est;
  assign out_collections    = out_snap_r.count;

endmodule

FILE: tb/sv/gc_trigger_policy_check.sv
`timescale 1ns / 1ps
// gc_trigger_policy_check: watches the config, request and result channels of
// gc_trigger_policy, predicts every result and compares it. Depends on gctp_pkg.
module gc_trigger_policy_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [gctp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gctp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [2:0]                      in_action,
  input  logic [gctp_pkg::BYTE_W-1:0]     in_heap_bytes,
  input  logic [gctp_pkg::BYTE_W-1:0]     in_nursery_used,
  input  logic [gctp_pkg::BYTE_W-1:0]     in_live_bytes,
  input  logic [gctp_pkg::FRAG_W-1:0]     in_fragmentation,
  input  logic [2:0]                      in_trigger_in,
  input  logic [gctp_pkg::BYTE_W-1:0]     in_alloc_bytes,
  input  logic [gctp_pkg::DUR_W-1:0]      in_duration,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [2:0]                      out_trigger,
  input  logic [1:0]                      out_kind,
  input  logic [gctp_pkg::BYTE_W-1:0]     out_bytes_until_gc,
  input  logic [gctp_pkg::BYTE_W-1:0]     out_predicted_live,
  input  logic [gctp_pkg::BYTE_W-1:0]     out_last_live,
  input  logic [gctp_pkg::DUR_W-1:0]      out_mean_duration,
  input  logic [gctp_pkg::CNT_W-1:0]      out_collections,
  output int                              mismatches,
  output int                              results_checked,
  output int                              results_pending
);
  import gctp_pkg::*;

  localparam logic [63:0] BYTE_MAX = (64'd1 << BYTE_W) - 64'd1;
  localparam int          MAX_REPORTS = 10;

  typedef struct packed {
    trig_t              trig;
    kind_t              kind;
    logic [BYTE_W-1:0]  until_gc;
    logic [BYTE_W-1:0]  live_est;
    logic [BYTE_W-1:0]  last_live;
    logic [DUR_W-1:0]   mean_dur;
    logic [CNT_W-1:0]   count;
  } result_t;

  // register copies
  logic [BYTE_W-1:0]   nursery_limit;
  logic [BYTE_W-1:0]   major_floor;
  logic [GAIN_W-1:0]   growth_gain;
  logic [TIME_W-1:0]   time_limit;
  logic [SMOOTH_W-1:0] smooth_gain;

  // scheduler state
  logic [TIME_W-1:0]   elapsed;
  logic [BYTE_W-1:0]   live_at_last;
  logic [BYTE_W-1:0]   allocated;
  logic [BYTE_W-1:0]   live_est;
  logic [DUR_W-1:0]    dur_est;
  logic [CNT_W-1:0]    completed;

  result_t expected_results[$];

  // max(floor, live * growth / 256), product saturated to the byte range
  function automatic logic [BYTE_W-1:0] grown_threshold(input logic [BYTE_W-1:0] live);
    logic [63:0] scaled;
    scaled = (64'(live) * 64'(growth_gain)) >> 8;
    if (scaled > BYTE_MAX) scaled = BYTE_MAX;
    if (scaled[BYTE_W-1:0] > major_floor) return scaled[BYTE_W-1:0];
    return major_floor;
  endfunction

  // exponential average, seeded by the sample while still zero
  function automatic logic [63:0] smoothed(input logic [63:0] old, input logic [63:0] sample);
    logic [63:0] w;
    logic [63:0] prod;
    w = (smooth_gain > SMOOTH_ONE) ? 64'd256 : 64'(smooth_gain);
    if (old == 64'd0) return sample;
    if (sample >= old) return old + (((sample - old) * w) >> 8);
    // moving down rounds the step up
    prod = (old - sample) * w;
    return old - ((prod >> 8) + 64'(prod[7:0] != 8'd0));
  endfunction

  function automatic kind_t kind_of(input trig_t trig, input logic [BYTE_W-1:0] heap,
                                    input logic [FRAG_W-1:0] frag);
    case (trig)
      TRG_BUDGET: begin
        if (heap < major_floor) return KIND_MINOR;
        if (frag >= FRAG_COMPACT) return KIND_COMPACT;
        return KIND_MAJOR;
      end
      TRG_TIME, TRG_PROACTIVE: return KIND_MAJOR;
      TRG_PRESSURE, TRG_EXPLICIT: return KIND_FULL;
      default: return KIND_MINOR;
    endcase
  endfunction

  // apply one request to the state and form its result
  function automatic result_t policy_result(
    input logic [2:0] action, input logic [BYTE_W-1:0] heap, input logic [BYTE_W-1:0] nursery,
    input logic [BYTE_W-1:0] live, input logic [FRAG_W-1:0] frag, input logic [2:0] tin,
    input logic [BYTE_W-1:0] alloc, input logic [DUR_W-1:0] dur);
    result_t r;
    logic [63:0] sum;
    logic [BYTE_W-1:0] thr;
    r = '0;
    r.trig = TRG_NONE;
    r.kind = KIND_MINOR;
    case (action_t'(action))
      ACT_TICK: begin
        if (elapsed != '1) elapsed = elapsed + 1'b1;
      end
      ACT_CHECK: begin
        if (nursery >= nursery_limit) r.trig = TRG_BUDGET;
        else if (heap >= grown_threshold(live_at_last)) r.trig = TRG_BUDGET;
        else if (elapsed >= time_limit) r.trig = TRG_TIME;
        r.kind = kind_of(r.trig, heap, frag);
      end
      ACT_SELECT: begin
        r.trig = (tin > TRG_EXPLICIT) ? TRG_NONE : trig_t'(tin);
        r.kind = kind_of(r.trig, heap, frag);
      end
      ACT_ALLOC: begin
        sum = 64'(allocated) + 64'(alloc);
        allocated = (sum > BYTE_MAX) ? BYTE_MAX[BYTE_W-1:0] : sum[BYTE_W-1:0];
      end
      ACT_COMPLETE: begin
        elapsed = '0;
        allocated = '0;
        if (completed != '1) completed = completed + 1'b1;
        live_est = BYTE_W'(smoothed(64'(live_est), 64'(live)));
        dur_est = DUR_W'(smoothed(64'(dur_est), 64'(dur)));
        live_at_last = live;
      end
      default: ;
    endcase
    thr = grown_threshold(live_est);
    r.until_gc  = (thr > allocated) ? thr - allocated : '0;
    r.live_est  = live_est;
    r.last_live = live_at_last;
    r.mean_dur  = dur_est;
    r.count     = completed;
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s: expected trig %0d kind %0d until %0d live %0d last %0d dur %0d count %0d",
               what, want.trig, want.kind, want.until_gc, want.live_est, want.last_live,
               want.mean_dur, want.count);
      $display("  got trig %0d kind %0d until %0d live %0d last %0d dur %0d count %0d",
               got.trig, got.kind, got.until_gc, got.live_est, got.last_live,
               got.mean_dur, got.count);
    end
  endfunction

  initial begin
    mismatches = 0;
    results_checked = 0;
    results_pending = 0;
  end

  // watch the three channels; results are matched before new requests are queued
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst_n) begin
      nursery_limit = NURSERY_LIMIT_RST;
      major_floor   = MAJOR_FLOOR_RST;
      growth_gain   = GROWTH_GAIN_RST;
      time_limit    = TIME_LIMIT_RST;
      smooth_gain   = SMOOTH_GAIN_RST;
      elapsed       = '0;
      live_at_last  = '0;
      allocated     = '0;
      live_est      = '0;
      dur_est       = '0;
      completed     = '0;
      expected_results.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NURSERY_LIMIT: nursery_limit = cfg_data[BYTE_W-1:0];
          CFG_MAJOR_FLOOR:   major_floor   = cfg_data[BYTE_W-1:0];
          CFG_GROWTH_GAIN:   growth_gain   = cfg_data[GAIN_W-1:0];
          CFG_TIME_LIMIT:    time_limit    = cfg_data[TIME_W-1:0];
          CFG_SMOOTH_GAIN:   smooth_gain   = cfg_data[SMOOTH_W-1:0];
          default: ;
        endcase
      end
      // result side
      if (out_valid && out_ready) begin
        got.trig      = trig_t'(out_trigger);
        got.kind      = kind_t'(out_kind);
        got.until_gc  = out_bytes_until_gc;
        got.live_est  = out_predicted_live;
        got.last_live = out_last_live;
        got.mean_dur  = out_mean_duration;
        got.count     = out_collections;
        if (expected_results.size() == 0) begin
          note_mismatch("result with no request pending", '0, got);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want != got) note_mismatch("result mismatch", want, got);
        end
      end
      // request side
      if (in_valid && in_ready) begin
        expected_results.push_back(policy_result(in_action, in_heap_bytes, in_nursery_used,
                                                 in_live_bytes, in_fragmentation,
                                                 in_trigger_in, in_alloc_bytes, in_duration));
      end
    end
    results_pending = expected_results.size();
  end

endmodule

FILE: tb/sv/gc_trigger_policy_test.sv
`timescale 1ns / 1ps
// gc_trigger_policy_test: clock, reset and request stimulus for gc_trigger_policy
// over several register settings. Depends on gctp_pkg and gc_trigger_policy_check.
module gc_trigger_policy_test;
  import gctp_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 275;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 8;
  localparam int IDLE_PERCENT    = 17;

  // codes outside the defined sets
  localparam logic [2:0]           ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0]           ACT_UNUSED_HI = 3'd7;
  localparam logic [2:0]           TRG_UNDEFINED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 3'd7;

  typedef struct {
    logic [2:0]        action;
    logic [BYTE_W-1:0] heap;
    logic [BYTE_W-1:0] nursery;
    logic [BYTE_W-1:0] live;
    logic [FRAG_W-1:0] frag;
    logic [2:0]        tin;
    logic [BYTE_W-1:0] alloc;
    logic [DUR_W-1:0]  dur;
  } request_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            in_action;
  logic [BYTE_W-1:0]     in_heap_bytes;
  logic [BYTE_W-1:0]     in_nursery_used;
  logic [BYTE_W-1:0]     in_live_bytes;
  logic [FRAG_W-1:0]     in_fragmentation;
  logic [2:0]            in_trigger_in;
  logic [BYTE_W-1:0]     in_alloc_bytes;
  logic [DUR_W-1:0]      in_duration;
  logic                  out_valid;
  logic                  out_ready;
  logic [2:0]            out_trigger;
  logic [1:0]            out_kind;
  logic [BYTE_W-1:0]     out_bytes_until_gc;
  logic [BYTE_W-1:0]     out_predicted_live;
  logic [BYTE_W-1:0]     out_last_live;
  logic [DUR_W-1:0]      out_mean_duration;
  logic [CNT_W-1:0]      out_collections;
  int                    mismatches;
  int                    results_checked;
  int                    results_pending;

  // stimulus bookkeeping
  logic              no_idle;
  logic              hold_go;
  logic              hold_done;
  logic [BYTE_W-1:0] near_nursery;
  logic [BYTE_W-1:0] near_floor;
  int                action_seen[8];
  int                settings;
  int                cycle_count;

  gc_trigger_policy dut (.*);

  gc_trigger_policy_check policy_check (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // byte values: zero, full scale, wide random, random magnitude, small random, or close to a boundary
  function automatic logic [BYTE_W-1:0] pick_bytes(input logic [BYTE_W-1:0] near);
    logic [BYTE_W-1:0] wide;
    wide = BYTE_W'({$urandom, $urandom});
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return wide;
      3: return wide >> $urandom_range(BYTE_W - 1);
      4, 5: return near + BYTE_W'($urandom_range(64)) - BYTE_W'(32);
      default: return BYTE_W'($urandom_range(1 << 16));
    endcase
  endfunction

  function automatic request_t random_request(input logic [2:0] act);
    request_t req;
    req.action  = act;
    req.heap    = pick_bytes(near_floor);
    req.nursery = pick_bytes(near_nursery);
    req.live    = pick_bytes(near_floor >> 1);
    req.alloc   = pick_bytes(BYTE_W'(1) << 20);
    case ($urandom_range(3))
      0: req.frag = FRAG_W'($urandom_range(511));
      1: req.frag = FRAG_W'(FRAG_COMPACT - 1 + $urandom_range(2));
      default: req.frag = FRAG_W'($urandom_range(256));
    endcase
    req.tin = 3'($urandom_range(7));
    req.dur = ($urandom_range(2) == 0) ? DUR_W'($urandom) : DUR_W'($urandom_range(1 << 16));
    return req;
  endfunction

  function automatic logic [2:0] random_action();
    int r;
    r = $urandom_range(99);
    if (r < 25) return ACT_TICK;
    if (r < 50) return ACT_CHECK;
    if (r < 62) return ACT_SELECT;
    if (r < 80) return ACT_ALLOC;
    if (r < 95) return ACT_COMPLETE;
    return 3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
  endfunction

  // offer one request after a random gap and wait for it to be taken
  task automatic send(input request_t req);
    int gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= req.action;
    in_heap_bytes    <= req.heap;
    in_nursery_used  <= req.nursery;
    in_live_bytes    <= req.live;
    in_fragmentation <= req.frag;
    in_trigger_in    <= req.tin;
    in_alloc_bytes   <= req.alloc;
    in_duration      <= req.dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    action_seen[req.action]++;
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // write all registers; unused upper data bits carry noise
  task automatic configure(input logic [BYTE_W-1:0] nl, input logic [BYTE_W-1:0] mf,
                           input logic [GAIN_W-1:0] gg, input logic [TIME_W-1:0] tl,
                           input logic [SMOOTH_W-1:0] sg);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'({$urandom, $urandom});
    write_reg(CFG_NURSERY_LIMIT, nl);
    write_reg(CFG_MAJOR_FLOOR, mf);
    write_reg(CFG_GROWTH_GAIN, {noise[CFG_DATA_W-1:GAIN_W], gg});
    write_reg(CFG_TIME_LIMIT, {noise[CFG_DATA_W-1:TIME_W], tl});
    write_reg(CFG_SMOOTH_GAIN, {noise[CFG_DATA_W-1:SMOOTH_W], sg});
    write_reg(CFG_UNUSED, noise);
    cfg_valid <= 1'b0;
    near_nursery = nl;
    near_floor = mf;
    settings++;
  endtask

  // result side: random stalls, plus one long hold while requests keep coming
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL gc_trigger_policy");
    $finish;
  end

  // stimulus and verdict
  initial begin
    request_t req;
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_action        = ACT_TICK;
    in_heap_bytes    = '0;
    in_nursery_used  = '0;
    in_live_bytes    = '0;
    in_fragmentation = '0;
    in_trigger_in    = TRG_NONE;
    in_alloc_bytes   = '0;
    in_duration      = '0;
    no_idle          = 1'b0;
    hold_go          = 1'b0;
    near_nursery     = NURSERY_LIMIT_RST;
    near_floor       = MAJOR_FLOOR_RST;
    settings         = 1;
    foreach (action_seen[i]) action_seen[i] = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: nursery at and just below its limit, heap at zero, full scale, and at and just below the floor
    req = random_request(ACT_TICK);
    send(req);
    req = random_request(ACT_CHECK);
    req.nursery = NURSERY_LIMIT_RST;
    req.heap = '0;
    send(req);
    req = random_request(ACT_CHECK);
    req.nursery = NURSERY_LIMIT_RST - 1'b1;
    req.heap = '1;
    req.frag = FRAG_COMPACT;
    send(req);
    req = random_request(ACT_CHECK);
    req.nursery = '0;
    req.heap = MAJOR_FLOOR_RST;
    req.frag = FRAG_W'(FRAG_COMPACT - 1);
    send(req);
    req = random_request(ACT_CHECK);
    req.nursery = '0;
    req.heap = MAJOR_FLOOR_RST - 1'b1;
    send(req);
    // every external trigger, the undefined one too
    for (int t = TRG_NONE; t <= TRG_UNDEFINED; t++) begin
      req = random_request(ACT_SELECT);
      req.tin = 3'(t);
      req.heap = t[0] ? '1 : '0;
      req.frag = t[1] ? '1 : '0;
      send(req);
    end
    // allocation saturation
    req = random_request(ACT_ALLOC);
    req.alloc = '1;
    send(req);
    send(req);
    // completions: seed at full scale, then drop to zero, then a mid value
    req = random_request(ACT_COMPLETE);
    req.live = '1;
    req.dur = '1;
    send(req);
    req.live = '0;
    req.dur = '0;
    send(req);
    req.live = BYTE_W'(1000000);
    req.dur = DUR_W'(12345);
    send(req);
    req = random_request(ACT_ALLOC);
    req.alloc = BYTE_W'(5000);
    send(req);
    req = random_request(ACT_CHECK);
    send(req);
    // undefined actions
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++) begin
      req = random_request(3'(a));
      send(req);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: configure('0, '0, '0, '0, '0);
          2: configure('1, '1, '1, '1, SMOOTH_ONE);
          3: configure(NURSERY_LIMIT_RST, BYTE_W'(1) << 22, GAIN_W'(256), TIME_W'(6), '1);
          default: configure(pick_bytes(near_nursery), pick_bytes(near_floor),
                             GAIN_W'($urandom), TIME_W'($urandom_range(40)),
                             SMOOTH_W'($urandom_range(511)));
        endcase
      end
      // one phase runs with no idling and the long output hold
      no_idle <= (p == 2);
      if (p == 2) hold_go <= 1'b1;
      repeat (ITEMS_PER_PHASE) send(random_request(random_action()));
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d ticks, %0d checks, %0d selects, %0d allocations, %0d completions,",
             action_seen[ACT_TICK], action_seen[ACT_CHECK], action_seen[ACT_SELECT],
             action_seen[ACT_ALLOC], action_seen[ACT_COMPLETE]);
    $display("%0d undefined actions over %0d register settings; %0d results compared, %0d bad",
             action_seen[5] + action_seen[6] + action_seen[7], settings, results_checked,
             mismatches);
    if (mismatches == 0 && results_pending == 0) begin
      $display("PASS gc_trigger_policy");
    end else begin
      $display("FAIL gc_trigger_policy");
    end
    $finish;
  end

endmodule
